### rtl/core/sph_pkg.sv
// Shared types, constants and round functions for the SipHash-2-4 tag check.
// No dependencies; sph_cell, sph_out, the top level and the bench import it.
`timescale 1ns / 1ps
`default_nettype none

package sph_pkg;

    // Initialization constants
    localparam logic [63:0] SPH_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SPH_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SPH_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SPH_C3 = 64'h7465646279746573;

    // Final length block (64 bytes in the top byte) and finalization mask
    localparam logic [63:0] SPH_LEN_BLOCK = 64'h4000000000000000;
    localparam logic [63:0] SPH_FIN_XOR   = 64'h00000000000000ff;

    localparam int SPH_MSG_WORDS = 8;
    // Nine absorbs of two rounds, four final rounds, two half-round cells each
    localparam int SPH_ABSORB_CELLS = (SPH_MSG_WORDS + 1) * 4;
    localparam int SPH_NUM_CELLS    = SPH_ABSORB_CELLS + 4 * 2;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } sph_state_t;

    // One beat as it travels down the cell row
    typedef struct packed {
        sph_state_t                          st;
        logic [SPH_MSG_WORDS-1:0][63:0]      words;
        logic [63:0]                         expected;
    } sph_beat_t;

    // Per-cell role, fixed by the cell's place in the row
    typedef struct packed {
        logic first_half;
        logic pre_xor;
        logic post_xor;
        logic fin_xor;
    } sph_ctrl_t;

    function automatic logic [63:0] sph_rotl(input logic [63:0] w, input int unsigned n);
        sph_rotl = (w << n) | (w >> (64 - n));
    endfunction

    // First half of a SipRound: two independent adds
    function automatic sph_state_t sph_half_a(input sph_state_t s);
        sph_state_t r;
        r   = s;
        r.a = r.a + r.b;
        r.b = sph_rotl(r.b, 13) ^ r.a;
        r.a = sph_rotl(r.a, 32);
        r.c = r.c + r.d;
        r.d = sph_rotl(r.d, 16) ^ r.c;
        sph_half_a = r;
    endfunction

    // Second half of a SipRound: two independent adds
    function automatic sph_state_t sph_half_b(input sph_state_t s);
        sph_state_t r;
        r   = s;
        r.a = r.a + r.d;
        r.d = sph_rotl(r.d, 21) ^ r.a;
        r.c = r.c + r.b;
        r.b = sph_rotl(r.b, 17) ^ r.c;
        r.c = sph_rotl(r.c, 32);
        sph_half_b = r;
    endfunction

    // Role of the cell at a given place in the row
    function automatic sph_ctrl_t sph_cell_ctrl(input logic [5:0] idx);
        sph_ctrl_t c;
        logic      absorb;
        absorb       = (idx < 6'(SPH_ABSORB_CELLS));
        c.first_half = (idx[0] == 1'b0);
        c.pre_xor    = absorb && (idx[1:0] == 2'b00);
        c.post_xor   = absorb && (idx[1:0] == 2'b11);
        c.fin_xor    = (idx == 6'(SPH_ABSORB_CELLS - 1));
        sph_cell_ctrl = c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sph_in_if.sv
// Request channel: key, message words and expected tag with valid/ready.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sph_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [63:0] msg_word_0;
    logic [63:0] msg_word_1;
    logic [63:0] msg_word_2;
    logic [63:0] msg_word_3;
    logic [63:0] msg_word_4;
    logic [63:0] msg_word_5;
    logic [63:0] msg_word_6;
    logic [63:0] msg_word_7;
    logic [63:0] expected_tag;

    modport source (
        output valid, key_low, key_high, msg_word_0, msg_word_1, msg_word_2,
               msg_word_3, msg_word_4, msg_word_5, msg_word_6, msg_word_7,
               expected_tag,
        input  ready
    );

    modport sink (
        input  valid, key_low, key_high, msg_word_0, msg_word_1, msg_word_2,
               msg_word_3, msg_word_4, msg_word_5, msg_word_6, msg_word_7,
               expected_tag,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/sph_out_if.sv
// Response channel: computed tag and match flag with valid/ready.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sph_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_tag;
    logic        tag_match;

    modport source (
        output valid, hash_tag, tag_match,
        input  ready
    );

    modport sink (
        input  valid, hash_tag, tag_match,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/sph_cell.sv
// One cell of the SipHash row: a registered half-round with optional absorb.
// Depends on sph_pkg for the beat type, control struct and round functions.
`timescale 1ns / 1ps
`default_nettype none

module sph_cell
    import sph_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire sph_ctrl_t ctrl,
    input  wire logic      vld_in,
    input  wire sph_beat_t beat_in,
    output logic           vld_out,
    output sph_beat_t      beat_out
);

    logic      vld_reg;
    sph_beat_t beat_reg;
    sph_beat_t beat_next;

    // Inject word, half-round, close absorb, shift word queue, final XOR
    always_comb
    begin
        sph_state_t                     s;
        logic [SPH_MSG_WORDS-1:0][63:0] w;
        s = beat_in.st;
        w = beat_in.words;
        if (ctrl.pre_xor)
        begin
            s.d = s.d ^ w[0];
        end
        if (ctrl.first_half)
        begin
            s = sph_half_a(s);
        end
        else
        begin
            s = sph_half_b(s);
        end
        if (ctrl.post_xor)
        begin
            s.a = s.a ^ w[0];
            w   = {SPH_LEN_BLOCK, w[SPH_MSG_WORDS-1:1]};
        end
        if (ctrl.fin_xor)
        begin
            s.c = s.c ^ SPH_FIN_XOR;
        end
        beat_next.st       = s;
        beat_next.words    = w;
        beat_next.expected = beat_in.expected;
    end

    // Hold the valid bit while the row is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= vld_in;
        end
    end

    // Payload moves with the row, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            beat_reg <= beat_next;
        end
    end

    assign vld_out  = vld_reg;
    assign beat_out = beat_reg;

endmodule

`default_nettype wire

### rtl/core/sph_out.sv
// Output stage: folds the final state into the tag, compares, holds the beat.
// Depends on sph_pkg for the beat type.
`timescale 1ns / 1ps
`default_nettype none

module sph_out
    import sph_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      vld_in,
    input  wire sph_beat_t beat_in,
    input  wire logic      ready,
    output logic           advance,
    output logic           valid,
    output logic [63:0]    hash_tag,
    output logic           tag_match
);

    logic        vld_reg;
    logic [63:0] tag_reg;
    logic        match_reg;
    logic [63:0] tag_next;

    // Move when the output slot is empty or being drained this cycle
    assign advance  = !vld_reg || ready;
    assign tag_next = beat_in.st.a ^ beat_in.st.b ^ beat_in.st.c ^ beat_in.st.d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= vld_in;
        end
    end

    // Capture tag and comparison result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tag_reg   <= tag_next;
            match_reg <= (tag_next == beat_in.expected);
        end
    end

    assign valid     = vld_reg;
    assign hash_tag  = tag_reg;
    assign tag_match = match_reg;

endmodule

`default_nettype wire

### rtl/core/siphash24_tag_check.sv
// SipHash-2-4 tag check, top level.
// Depends on sph_pkg, sph_in_if, sph_out_if, sph_cell and sph_out.
//
// Usage:
//   req carries one beat per packet: key_low/key_high (k0/k1), eight
//   little-endian message words and the expected tag. rsp returns one beat
//   per request with the computed tag and a match flag, in request order.
//   Throughput: one beat per cycle. The hash runs down a row of 44 cells,
//   each doing one registered half SipRound (two 64-bit adds); nine absorbs
//   of two rounds and four finalization rounds fill the row.
//   Pipeline: the accepting edge loads the first of 45 register stages
//   (44 cells plus the output register that folds and compares the tag).
//   Stall: when rsp is held valid and not ready, the whole row freezes and
//   req.ready drops in the same cycle; nothing is lost or repeated.
//   Reset: rst_n clears every valid bit at once; no clearing pass, the
//   block takes a request in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module siphash24_tag_check
    import sph_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sph_in_if.sink    req,
    sph_out_if.source rsp
);

    logic                     advance;
    logic [SPH_NUM_CELLS:0]   cell_vld;
    sph_beat_t                cell_beat [0:SPH_NUM_CELLS];

    // Build the initial state and word queue from the request beat
    assign cell_vld[0]           = req.valid;
    assign cell_beat[0].st.a     = req.key_low ^ SPH_C0;
    assign cell_beat[0].st.b     = req.key_high ^ SPH_C1;
    assign cell_beat[0].st.c     = req.key_low ^ SPH_C2;
    assign cell_beat[0].st.d     = req.key_high ^ SPH_C3;
    assign cell_beat[0].words    = {req.msg_word_7, req.msg_word_6, req.msg_word_5,
                                    req.msg_word_4, req.msg_word_3, req.msg_word_2,
                                    req.msg_word_1, req.msg_word_0};
    assign cell_beat[0].expected = req.expected_tag;

    assign req.ready = advance;

    // Row of half-round cells
    for (genvar i = 0; i < SPH_NUM_CELLS; i++)
    begin : g_cell
        sph_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .ctrl     (sph_cell_ctrl(6'(i))),
            .vld_in   (cell_vld[i]),
            .beat_in  (cell_beat[i]),
            .vld_out  (cell_vld[i+1]),
            .beat_out (cell_beat[i+1])
        );
    end

    sph_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld_in    (cell_vld[SPH_NUM_CELLS]),
        .beat_in   (cell_beat[SPH_NUM_CELLS]),
        .ready     (rsp.ready),
        .advance   (advance),
        .valid     (rsp.valid),
        .hash_tag  (rsp.hash_tag),
        .tag_match (rsp.tag_match)
    );

    // A held response must block new requests
    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("request accepted while response stalled");

    // An accepted request lands in the first cell
    a_accept_enters_row: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> cell_vld[1])
        else $error("accepted request missing from first cell");

    // A frozen row keeps its occupancy
    a_frozen_row: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cell_vld[SPH_NUM_CELLS:1]))
        else $error("cell row moved while stalled");

    // The last cell's beat reaches the output when the row moves
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cell_vld[SPH_NUM_CELLS]) |=> rsp.valid)
        else $error("beat dropped between last cell and output");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking bench for the SipHash-2-4 tag check: drives request beats,
// predicts each tag and match flag, and compares every response beat in order.
// Depends on sph_pkg, sph_in_if, sph_out_if and siphash24_tag_check.
`timescale 1ns / 1ps

module testbench;
    import sph_pkg::*;

    localparam int RANDOM_PER_PHASE = 163;
    localparam int IDLE_LIMIT       = 4000;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_CYCLES     = 60;

    typedef enum int {TAG_CORRECT, TAG_FLIP_LOW, TAG_FLIP_HIGH, TAG_RANDOM} tag_kind_e;

    typedef struct {
        logic [63:0]      key_low;
        logic [63:0]      key_high;
        logic [7:0][63:0] msg_words;
        logic [63:0]      expected_tag;
    } request_t;

    typedef struct {
        logic [63:0] hash_tag;
        logic        tag_match;
    } tag_result_t;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_rsp;
    int   idle_cycles;

    sph_in_if  req_if ();
    sph_out_if rsp_if ();

    siphash24_tag_check dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // 64-bit left rotate
    function automatic logic [63:0] rotl64(input logic [63:0] w, input int n);
        return (w << n) | (w >> (64 - n));
    endfunction

    // One full SipRound on the four lanes
    function automatic void sip_round(inout logic [63:0] v0, v1, v2, v3);
        v0 = v0 + v1; v1 = rotl64(v1, 13) ^ v0; v0 = rotl64(v0, 32);
        v2 = v2 + v3; v3 = rotl64(v3, 16) ^ v2;
        v0 = v0 + v3; v3 = rotl64(v3, 21) ^ v0;
        v2 = v2 + v1; v1 = rotl64(v1, 17) ^ v2; v2 = rotl64(v2, 32);
    endfunction

    // SipHash-2-4 over eight words plus the length block
    function automatic logic [63:0] siphash_tag(input request_t r);
        logic [63:0] v0, v1, v2, v3, m;
        v0 = r.key_low ^ SPH_C0;
        v1 = r.key_high ^ SPH_C1;
        v2 = r.key_low ^ SPH_C2;
        v3 = r.key_high ^ SPH_C3;
        for (int i = 0; i <= SPH_MSG_WORDS; i++)
        begin
            m = (i == SPH_MSG_WORDS) ? SPH_LEN_BLOCK : r.msg_words[i];
            v3 = v3 ^ m;
            sip_round(v0, v1, v2, v3);
            sip_round(v0, v1, v2, v3);
            v0 = v0 ^ m;
        end
        v2 = v2 ^ SPH_FIN_XOR;
        for (int i = 0; i < 4; i++)
            sip_round(v0, v1, v2, v3);
        return v0 ^ v1 ^ v2 ^ v3;
    endfunction

    // Mostly random words, with the all-zero and all-one extremes mixed in
    function automatic logic [63:0] rand64();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_expected(input logic [63:0] tag, input tag_kind_e kind);
        case (kind)
            TAG_CORRECT:   return tag;
            TAG_FLIP_LOW:  return tag ^ 64'h1;
            TAG_FLIP_HIGH: return tag ^ (64'h1 << 63);
            default:       return rand64();
        endcase
    endfunction

    // Directed beat: words follow base + i * step
    function automatic request_t make_request(input logic [63:0] k0, k1, base, step,
                                              input tag_kind_e kind);
        request_t r;
        r.key_low  = k0;
        r.key_high = k1;
        for (int i = 0; i < SPH_MSG_WORDS; i++)
            r.msg_words[i] = base + 64'(i) * step;
        r.expected_tag = pick_expected(siphash_tag(r), kind);
        return r;
    endfunction

    // Random beat: about half carry the right tag, the rest near misses or noise
    function automatic request_t random_request();
        request_t  r;
        int        pick;
        tag_kind_e kind;
        r.key_low  = rand64();
        r.key_high = rand64();
        for (int i = 0; i < SPH_MSG_WORDS; i++)
            r.msg_words[i] = rand64();
        pick = $urandom_range(7);
        if (pick < 4)
            kind = TAG_CORRECT;
        else if (pick == 4)
            kind = TAG_FLIP_LOW;
        else if (pick == 5)
            kind = TAG_FLIP_HIGH;
        else
            kind = TAG_RANDOM;
        r.expected_tag = pick_expected(siphash_tag(r), kind);
        return r;
    endfunction

    // Holds the predicted responses in request order and checks each one
    class tag_scoreboard;
        tag_result_t pending_tags[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_request(input request_t r);
            tag_result_t t;
            t.hash_tag  = siphash_tag(r);
            t.tag_match = (t.hash_tag == r.expected_tag);
            pending_tags.push_back(t);
        endfunction

        task check_response(input logic [63:0] tag, input logic match);
            tag_result_t t;
            if (pending_tags.size() == 0)
            begin
                report($sformatf("response beat with no request pending, tag %h", tag));
                return;
            end
            t = pending_tags.pop_front();
            if (tag !== t.hash_tag)
                report($sformatf("hash_tag %h, predicted %h", tag, t.hash_tag));
            if (match !== t.tag_match)
                report($sformatf("tag_match %b, predicted %b (tag %h)",
                                 match, t.tag_match, t.hash_tag));
        endtask
    endclass

    tag_scoreboard sb = new();

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Drive response ready; a hold-off forces it low
    always @(posedge clk)
    begin
        if (rst_n)
            rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
    end

    // Check response beats; signals are stable at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.hash_tag, rsp_if.tag_match);
    end

    // Watchdog: count cycles with no beat on either channel
    always @(negedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one beat, idling at random first; returns at the accepting edge
    task automatic send_request(input request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.key_low      <= r.key_low;
        req_if.key_high     <= r.key_high;
        req_if.msg_word_0   <= r.msg_words[0];
        req_if.msg_word_1   <= r.msg_words[1];
        req_if.msg_word_2   <= r.msg_words[2];
        req_if.msg_word_3   <= r.msg_words[3];
        req_if.msg_word_4   <= r.msg_words[4];
        req_if.msg_word_5   <= r.msg_words[5];
        req_if.msg_word_6   <= r.msg_words[6];
        req_if.msg_word_7   <= r.msg_words[7];
        req_if.expected_tag <= r.expected_tag;
        req_if.valid        <= 1'b1;
        @(negedge clk);
        while (!req_if.ready)
            @(negedge clk);
        sb.note_request(r);
        @(posedge clk);
    endtask

    // Stall the response side for a long stretch while requests keep coming
    task automatic hold_responses(input int cycles);
        fork
            begin
                @(posedge clk);
                hold_rsp <= 1'b1;
                repeat (cycles) @(posedge clk);
                hold_rsp <= 1'b0;
            end
        join_none
    endtask

    task automatic run_random(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_request(random_request());
    endtask

    initial
    begin
        rst_n               = 1'b0;
        hold_rsp            = 1'b0;
        idle_cycles         = 0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        req_if.valid        = 1'b0;
        req_if.key_low      = '0;
        req_if.key_high     = '0;
        req_if.msg_word_0   = '0;
        req_if.msg_word_1   = '0;
        req_if.msg_word_2   = '0;
        req_if.msg_word_3   = '0;
        req_if.msg_word_4   = '0;
        req_if.msg_word_5   = '0;
        req_if.msg_word_6   = '0;
        req_if.msg_word_7   = '0;
        req_if.expected_tag = '0;
        rsp_if.ready        = 1'b0;

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, patterned words, hits, near misses and noise
        send_request(make_request('0, '0, '0, '0, TAG_CORRECT));
        send_request(make_request('0, '0, '0, '0, TAG_RANDOM));
        send_request(make_request('1, '1, '1, '0, TAG_CORRECT));
        send_request(make_request('1, '1, '1, '0, TAG_FLIP_LOW));
        send_request(make_request('0, '1, '1, '0, TAG_FLIP_HIGH));
        send_request(make_request('1, '0, '0, '0, TAG_CORRECT));
        send_request(make_request(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                                  64'h0706050403020100, 64'h0808080808080808, TAG_CORRECT));
        send_request(make_request(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                                  64'h5555555555555555, 64'h5555555555555555, TAG_CORRECT));
        send_request(make_request(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                                  64'haaaaaaaaaaaaaaaa, 64'h0, TAG_FLIP_LOW));
        send_request(make_request(64'h1, 64'h8000000000000000,
                                  64'h1, 64'h1, TAG_FLIP_HIGH));
        send_request(make_request(64'h8000000000000000, 64'h1,
                                  64'hffffffffffffffff, 64'hffffffffffffffff, TAG_RANDOM));
        send_request(make_request(64'hdeadbeefcafef00d, 64'h0123456789abcdef,
                                  64'h0, 64'h0101010101010101, TAG_CORRECT));

        // Random: sender idles less, receiver more, with one long hold-off
        hold_responses(HOLD_CYCLES);
        run_random(24, 61);
        // Swap the idle rates
        run_random(61, 24);
        // No idling, back to back, with another hold-off
        hold_responses(HOLD_CYCLES);
        run_random(0, 0);
        req_if.valid <= 1'b0;

        // Drain, then watch for stray responses
        while (sb.pending_tags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/core/sph_pkg.sv
rtl/core/sph_in_if.sv
rtl/core/sph_out_if.sv
rtl/core/sph_cell.sv
rtl/core/sph_out.sv
rtl/core/siphash24_tag_check.sv
test/testbench.sv
